FILE: hdl/mac_pkg.sv
// Shared types and constants for the mask alpha composite unit.
`default_nettype none
package mac_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PREP,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_SCALE,
    ST_OUT
  } state_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BASE_WIDTH,
    CFG_BASE_HEIGHT,
    CFG_MASK_WIDTH,
    CFG_MASK_HEIGHT
  } cfg_idx_e;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_BASE = 1'b1;

  // Field widths
  localparam int CH_W       = 8;
  localparam int DIM_W      = 11;
  localparam int MDIM_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ENTRY_W    = 16;

  // Mask index and mask size widths (7x7 product, size compare up to 65536)
  localparam int IDX_W  = 2 * MDIM_W;
  localparam int SIZE_W = 17;

  // Coordinate divider: (coord * mask_dim) / base_dim
  localparam int DVD_W      = DIM_W + MDIM_W;
  localparam int DVS_W      = DIM_W;
  localparam int QUO_W      = MDIM_W;
  localparam int DIV_CNT_W  = 5;

  // Arithmetic constants
  localparam logic [CH_W-1:0] CH_MAX     = 8'd255;
  localparam logic [15:0]     ROUND_HALF = 16'd127;
  localparam logic [9:0]      LUMA_RECIP = 10'd683;  // ~2^11 / 3
  localparam int              LUMA_SHIFT = 11;
  localparam int              DIV255_SH  = 8;

endpackage
`default_nettype wire

FILE: hdl/mac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire                                      clk_i,
  input  wire                                      we_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire [WIDTH-1:0]                          wdata_i,
  input  wire                                      re_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hdl/mac_div.sv
// Restoring divider, one quotient bit per cycle, for mask coordinate scaling.
`default_nettype none
module mac_div (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire [mac_pkg::DVD_W-1:0]   dividend_i,
  input  wire [mac_pkg::DVS_W-1:0]   divisor_i,
  output logic                       busy_o,
  output logic [mac_pkg::QUO_W-1:0]  quot_o
);

  localparam int DvdW = mac_pkg::DVD_W;
  localparam int DvsW = mac_pkg::DVS_W;
  localparam int CntW = mac_pkg::DIV_CNT_W;

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvdW-1:0] dq_q, dq_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW:0]   rem_sh;
  logic [DvsW:0]   rem_sub;
  logic            fits;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_q, dq_q[DvdW-1]};
    fits    = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dq_d    = dq_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DvdW);
      rem_d  = '0;
      dq_d   = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[DvsW-1:0] : rem_sh[DvsW-1:0];
      dq_d  = {dq_q[DvdW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = dq_q[mac_pkg::QUO_W-1:0];

endmodule
`default_nettype wire

FILE: hdl/mask_alpha_composite_unit.sv
// Mask alpha composite unit: mask load, nearest-neighbor lookup and alpha scaling.
//
// Usage: write base_width, base_height, mask_width and mask_height over the
// cfg channel, then send mask pixels (req_type 0) in raster order, then base
// pixels (req_type 1) in raster order. Each base pixel yields one output beat
// with its color passed through and its alpha scaled by the inverted mask
// value (or passed through when a base or mask dimension is zero); frame_end
// marks the last pixel of the base image. Mask loads yield no output beat.
// Timing: one item is in flight at a time. A mask load passes through the
// load state. A base pixel with compositing enabled steps through accept,
// divider start, the divide state (waiting on the 18-step bit-serial
// coordinate dividers), address, registered mask RAM read, scale and output.
// A passed-through base pixel goes from accept straight to the output state.
// The result sits in an output register, so the next input beat is taken
// while a result waits; a stalled receiver holds the sequencer only when a
// second result is ready to be written.
// Reset clears the config and control registers, position and load count, not
// the payload registers; mask RAM is undefined until loaded (no clearing pass).
`default_nettype none
module mask_alpha_composite_unit #(
  parameter int MASK_PIXELS  = 4096,
  parameter int MAX_BASE_DIM = 1024
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // configuration channel
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire [mac_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [mac_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire                             req_type_i,
  input  wire [mac_pkg::CH_W-1:0]         red_i,
  input  wire [mac_pkg::CH_W-1:0]         green_i,
  input  wire [mac_pkg::CH_W-1:0]         blue_i,
  input  wire [mac_pkg::CH_W-1:0]         alpha_i,
  // output channel
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [mac_pkg::CH_W-1:0]        out_red_o,
  output logic [mac_pkg::CH_W-1:0]        out_green_o,
  output logic [mac_pkg::CH_W-1:0]        out_blue_o,
  output logic [mac_pkg::CH_W-1:0]        out_alpha_o,
  output logic                            frame_end_o
);

  localparam int ChW   = mac_pkg::CH_W;
  localparam int DimW  = mac_pkg::DIM_W;
  localparam int MdW   = mac_pkg::MDIM_W;
  localparam int IdxW  = mac_pkg::IDX_W;
  localparam int SizeW = mac_pkg::SIZE_W;
  localparam int AddrW = (MASK_PIXELS > 1) ? $clog2(MASK_PIXELS) : 1;
  localparam int CntW  = $clog2(MASK_PIXELS + 1);
  localparam int PosW  = (MAX_BASE_DIM > 1) ? $clog2(MAX_BASE_DIM) : 1;
  localparam logic [12:0]      MaxDim   = 13'(MAX_BASE_DIM);
  localparam logic [SizeW-1:0] MaskSize = SizeW'(MASK_PIXELS);

  // ---------------------------------------------------------------------
  // State
  mac_pkg::state_e state_q, state_d;

  logic [DimW-1:0] base_width_q, base_height_q;
  logic [MdW-1:0]  mask_width_q, mask_height_q;

  logic [CntW-1:0] load_count_q, load_count_d;
  logic [ChW-1:0]  first_alpha_q, first_alpha_d;
  logic            varies_q, varies_d;
  logic [PosW-1:0] column_q, column_d;
  logic [PosW-1:0] row_q, row_d;

  // item registers
  logic [ChW-1:0]  red_q, green_q, blue_q, alpha_q;
  logic [DimW-1:0] x_q, y_q, w_q, h_q;
  logic [ChW-1:0]  res_alpha_q;
  logic            frame_end_q;
  logic            oob_q;
  logic [15:0]     prod_q;

  // output register
  logic            out_valid_q;
  logic [ChW-1:0]  out_red_q, out_green_q, out_blue_q, out_alpha_q;
  logic            out_frame_end_q;

  // control
  logic in_ready, in_fire, div_start, ram_re, ram_we, out_load, out_free;
  logic busy_x, busy_y;
  logic [mac_pkg::QUO_W-1:0] quot_x, quot_y;
  logic [mac_pkg::ENTRY_W-1:0] ram_rdata;

  // ---------------------------------------------------------------------
  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_width_q  <= '0;
      base_height_q <= '0;
      mask_width_q  <= '0;
      mask_height_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (mac_pkg::cfg_idx_e'(cfg_index_i))
        mac_pkg::CFG_BASE_WIDTH:  base_width_q  <= cfg_data_i[DimW-1:0];
        mac_pkg::CFG_BASE_HEIGHT: base_height_q <= cfg_data_i[DimW-1:0];
        mac_pkg::CFG_MASK_WIDTH:  mask_width_q  <= cfg_data_i[MdW-1:0];
        mac_pkg::CFG_MASK_HEIGHT: mask_height_q <= cfg_data_i[MdW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Base position: clamp dimensions and position, compute next position
  logic [DimW-1:0] w_clamp, h_clamp, x_cur, y_cur, col_ext, row_ext;
  logic            dims_zero, mask_on, fe_cur;
  logic [PosW-1:0] col_next, row_next;

  always_comb begin
    w_clamp   = (13'(base_width_q) > MaxDim) ? DimW'(MAX_BASE_DIM) : base_width_q;
    h_clamp   = (13'(base_height_q) > MaxDim) ? DimW'(MAX_BASE_DIM) : base_height_q;
    dims_zero = (w_clamp == '0) || (h_clamp == '0);
    mask_on   = (mask_width_q != '0) && (mask_height_q != '0);
    col_ext   = DimW'(column_q);
    row_ext   = DimW'(row_q);
    x_cur     = (col_ext < w_clamp) ? col_ext : w_clamp - DimW'(1);
    y_cur     = (row_ext < h_clamp) ? row_ext : h_clamp - DimW'(1);
    fe_cur    = 1'b0;
    col_next  = '0;
    row_next  = row_q;
    if (dims_zero) begin
      row_next = '0;
      fe_cur   = 1'b1;
    end else if (x_cur >= w_clamp - DimW'(1)) begin
      if (y_cur >= h_clamp - DimW'(1)) begin
        row_next = '0;
        fe_cur   = 1'b1;
      end else begin
        row_next = PosW'(y_cur + DimW'(1));
      end
    end else begin
      // row register keeps its raw value while the column steps
      col_next = PosW'(x_cur + DimW'(1));
    end
  end

  // ---------------------------------------------------------------------
  // Mask load: size, slot, luma and first-alpha tracking
  logic [IdxW-1:0]  size_prod;
  logic [SizeW-1:0] mask_size, slot;
  logic [9:0]       rgb_sum;
  logic [18:0]      luma_prod;
  logic [ChW-1:0]   luma;

  always_comb begin
    size_prod = IdxW'(mask_width_q) * IdxW'(mask_height_q);
    mask_size = (SizeW'(size_prod) > MaskSize) ? MaskSize : SizeW'(size_prod);
    slot      = (SizeW'(load_count_q) >= mask_size) ? '0 : SizeW'(load_count_q);
    rgb_sum   = 10'(red_q) + 10'(green_q) + 10'(blue_q);
    luma_prod = 19'(rgb_sum) * 19'(mac_pkg::LUMA_RECIP);
    luma      = ChW'(luma_prod >> mac_pkg::LUMA_SHIFT);
    load_count_d  = load_count_q;
    first_alpha_d = first_alpha_q;
    varies_d      = varies_q;
    if (ram_we) begin
      load_count_d = CntW'(slot + SizeW'(1));
      if (slot == '0) begin
        first_alpha_d = alpha_q;
        varies_d      = 1'b0;
      end else if (alpha_q != first_alpha_q) begin
        varies_d = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Mask lookup address and alpha scaling
  logic [IdxW-1:0] mask_idx;
  logic            oob_d;
  logic [ChW-1:0]  mask_val;
  logic [15:0]     prod_d;
  logic [16:0]     rounded;
  logic [16:0]     div_sum;
  logic [ChW-1:0]  scaled;

  always_comb begin
    mask_idx = IdxW'(quot_y) * IdxW'(mask_width_q) + IdxW'(quot_x);
    oob_d    = SizeW'(mask_idx) >= MaskSize;
    if (oob_q) begin
      mask_val = '0;
    end else if (varies_q) begin
      mask_val = ram_rdata[15:8];
    end else begin
      mask_val = ram_rdata[7:0];
    end
    prod_d  = 16'(alpha_q) * 16'(mac_pkg::CH_MAX - mask_val);
    // v / 255 as (v + 1 + (v >> 8)) >> 8, exact for v below 2^16
    rounded = 17'(prod_q + mac_pkg::ROUND_HALF);
    div_sum = rounded + 17'd1 + (rounded >> mac_pkg::DIV255_SH);
    scaled  = ChW'(div_sum >> mac_pkg::DIV255_SH);
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  assign in_fire  = in_valid_i && in_ready;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mac_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (req_type_i == mac_pkg::REQ_LOAD) begin
            state_d = mac_pkg::ST_LOAD;
          end else if (dims_zero || !mask_on) begin
            state_d = mac_pkg::ST_OUT;
          end else begin
            state_d = mac_pkg::ST_PREP;
          end
        end
      end
      mac_pkg::ST_LOAD:  state_d = mac_pkg::ST_IDLE;
      mac_pkg::ST_PREP:  state_d = mac_pkg::ST_DIV;
      mac_pkg::ST_DIV: begin
        if (!busy_x && !busy_y) begin
          state_d = mac_pkg::ST_ADDR;
        end
      end
      mac_pkg::ST_ADDR:  state_d = mac_pkg::ST_READ;
      mac_pkg::ST_READ:  state_d = mac_pkg::ST_SCALE;
      mac_pkg::ST_SCALE: state_d = mac_pkg::ST_OUT;
      mac_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = mac_pkg::ST_IDLE;
        end
      end
      default: state_d = mac_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      mac_pkg::ST_IDLE:  in_ready  = 1'b1;
      mac_pkg::ST_LOAD:  ram_we    = mask_size != '0;
      mac_pkg::ST_PREP:  div_start = 1'b1;
      mac_pkg::ST_ADDR:  ram_re    = !oob_d;
      mac_pkg::ST_OUT:   out_load  = out_free;
      default: ;
    endcase
  end

  assign in_ready_o = in_ready;

  // ---------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mac_pkg::ST_IDLE;
      load_count_q  <= '0;
      first_alpha_q <= '0;
      varies_q      <= 1'b0;
      column_q      <= '0;
      row_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      load_count_q  <= load_count_d;
      first_alpha_q <= first_alpha_d;
      varies_q      <= varies_d;
      if (in_fire && req_type_i == mac_pkg::REQ_BASE) begin
        column_q <= col_next;
        row_q    <= row_next;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and output payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      red_q       <= red_i;
      green_q     <= green_i;
      blue_q      <= blue_i;
      alpha_q     <= alpha_i;
      x_q         <= x_cur;
      y_q         <= y_cur;
      w_q         <= w_clamp;
      h_q         <= h_clamp;
      frame_end_q <= fe_cur;
      res_alpha_q <= alpha_i;
    end else if (state_q == mac_pkg::ST_SCALE) begin
      res_alpha_q <= scaled;
    end
    if (state_q == mac_pkg::ST_ADDR) begin
      oob_q <= oob_d;
    end
    if (state_q == mac_pkg::ST_READ) begin
      prod_q <= prod_d;
    end
    if (out_load) begin
      out_red_q       <= red_q;
      out_green_q     <= green_q;
      out_blue_q      <= blue_q;
      out_alpha_q     <= res_alpha_q;
      out_frame_end_q <= frame_end_q;
    end
  end

  // ---------------------------------------------------------------------
  // Coordinate dividers: mx = x*mw/w, my = y*mh/h
  mac_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mac_pkg::DVD_W'(x_q) * mac_pkg::DVD_W'(mask_width_q)),
    .divisor_i  (w_q),
    .busy_o     (busy_x),
    .quot_o     (quot_x)
  );

  mac_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mac_pkg::DVD_W'(y_q) * mac_pkg::DVD_W'(mask_height_q)),
    .divisor_i  (h_q),
    .busy_o     (busy_y),
    .quot_o     (quot_y)
  );

  // Mask store: {alpha, luma} per entry
  mac_ram #(
    .WIDTH (mac_pkg::ENTRY_W),
    .DEPTH (MASK_PIXELS)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(slot)),
    .wdata_i ({alpha_q, luma}),
    .re_i    (ram_re),
    .raddr_i (AddrW'(mask_idx)),
    .rdata_o (ram_rdata)
  );

  // Output ports
  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_red_q;
  assign out_green_o = out_green_q;
  assign out_blue_o  = out_blue_q;
  assign out_alpha_o = out_alpha_q;
  assign frame_end_o = out_frame_end_q;

endmodule
`default_nettype wire
